### hdl/svkf_pkg.sv
// Package for the servo keyframe table: table sizes, derived widths,
// command/result payload types, codes and the controller/datapath interface.
// No dependencies.
package svkf_pkg;

    // Table sizes
    localparam int MAX_PATTERNS     = 8;
    localparam int MAX_TRAJECTORIES = 32;
    localparam int MAX_KEYFRAMES    = 256;

    // Field widths
    localparam int PAT_W  = 8;
    localparam int SRV_W  = 5;
    localparam int TIME_W = 16;
    localparam int ANG_W  = 12;
    localparam int STAT_W = 3;

    // Fill counts hold 0..MAX, addresses 0..MAX-1
    localparam int PAT_CW  = $clog2(MAX_PATTERNS + 1);
    localparam int TRJ_CW  = $clog2(MAX_TRAJECTORIES + 1);
    localparam int KEY_CW  = $clog2(MAX_KEYFRAMES + 1);
    localparam int PAT_AW  = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;
    localparam int TRJ_AW  = (MAX_TRAJECTORIES > 1) ? $clog2(MAX_TRAJECTORIES) : 1;
    localparam int KEY_AW  = $clog2(MAX_KEYFRAMES);
    localparam int IDX_W0  = (PAT_CW > TRJ_CW) ? PAT_CW : TRJ_CW;
    localparam int IDX_W   = (IDX_W0 > KEY_CW) ? IDX_W0 : KEY_CW;

    // Operation codes
    typedef enum logic [1:0] {
        FN_ADD_PAT   = 2'd0,
        FN_ADD_TRAJ  = 2'd1,
        FN_ADD_KEY   = 2'd2,
        FN_GET_ANGLE = 2'd3
    } t_func;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_OK          = 3'd0,
        ST_DUP         = 3'd1,
        ST_NOPARENT    = 3'd2,
        ST_FULL        = 3'd3,
        ST_NONEIGHBOUR = 3'd4
    } t_status;

    // Command and result payloads
    typedef struct packed {
        t_func              func;
        logic [PAT_W-1:0]   pat_id;
        logic [SRV_W-1:0]   srv_id;
        logic [TIME_W-1:0]  time_point;
        logic [ANG_W-1:0]   angle;
    } t_cmd;

    typedef struct packed {
        t_status            status;
        logic [ANG_W-1:0]   angle_out;
    } t_rsp;

    // Table entries
    typedef struct packed {
        logic [PAT_W-1:0]   pat_id;
        logic [SRV_W-1:0]   srv_id;
    } t_trj_ent;

    typedef struct packed {
        logic [PAT_W-1:0]   pat_id;
        logic [SRV_W-1:0]   srv_id;
        logic [TIME_W-1:0]  time_point;
        logic [ANG_W-1:0]   angle;
    } t_key_ent;

    // Which table a scan walks
    typedef enum logic [1:0] {
        PH_PAT,
        PH_TRJ,
        PH_KEY
    } t_phase;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_PAT,
        S_TRJ,
        S_KEY,
        S_RESP
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic   load;       // capture the command
        logic   scan_init;  // restart the scan index
        logic   scan;       // walk the table of the current phase
        t_phase phase;
        logic   finish;     // resolve status, commit write, strobe result
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic   scan_done;
        logic   pat_hit;
        logic   trj_hit;
        t_func  func;
    } t_dp_sts;

endpackage

### hdl/svkf_ctrl.sv
// Controller for the servo keyframe table: sequences the pattern,
// trajectory and keyframe scans and the final commit. Depends on svkf_pkg.
module svkf_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  svkf_pkg::t_dp_sts i_sts,
    output svkf_pkg::t_dp_cmd o_dp_cmd
);
    import svkf_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath commands
    always_comb begin
        n_state            = r_state;
        o_dp_cmd           = '0;
        o_dp_cmd.phase     = PH_PAT;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_dp_cmd.load      = 1'b1;
                    o_dp_cmd.scan_init = 1'b1;
                    n_state            = S_PAT;
                end
            end
            S_PAT: begin
                o_dp_cmd.scan  = 1'b1;
                o_dp_cmd.phase = PH_PAT;
                if (i_sts.scan_done) begin
                    if (i_sts.func == FN_ADD_PAT || !i_sts.pat_hit) begin
                        n_state = S_RESP;
                    end else begin
                        o_dp_cmd.scan_init = 1'b1;
                        n_state            = S_TRJ;
                    end
                end
            end
            S_TRJ: begin
                o_dp_cmd.scan  = 1'b1;
                o_dp_cmd.phase = PH_TRJ;
                if (i_sts.scan_done) begin
                    if (i_sts.func == FN_ADD_TRAJ || !i_sts.trj_hit) begin
                        n_state = S_RESP;
                    end else begin
                        o_dp_cmd.scan_init = 1'b1;
                        n_state            = S_KEY;
                    end
                end
            end
            S_KEY: begin
                o_dp_cmd.scan  = 1'b1;
                o_dp_cmd.phase = PH_KEY;
                if (i_sts.scan_done) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                o_dp_cmd.finish = 1'b1;
                n_state         = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy = (r_state != S_IDLE);

endmodule

### hdl/svkf_dp.sv
// Datapath for the servo keyframe table: the three table memories, fill
// counts, scan index, match/neighbor tracking and result register.
// Depends on svkf_pkg.
module svkf_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  svkf_pkg::t_cmd    i_cmd,
    input  svkf_pkg::t_dp_cmd i_dp_cmd,
    output svkf_pkg::t_dp_sts o_sts,
    output logic              o_valid,
    output svkf_pkg::t_rsp    o_rsp
);
    import svkf_pkg::*;

    // Table memories
    logic [PAT_W-1:0] pat_mem [MAX_PATTERNS];
    t_trj_ent         trj_mem [MAX_TRAJECTORIES];
    t_key_ent         key_mem [MAX_KEYFRAMES];

    logic [PAT_CW-1:0] r_pat_cnt;
    logic [TRJ_CW-1:0] r_trj_cnt;
    logic [KEY_CW-1:0] r_key_cnt;

    t_cmd              r_cmd;
    logic [IDX_W-1:0]  r_idx;
    logic              r_rd_vld;
    logic [PAT_W-1:0]  r_pat_rd;
    t_trj_ent          r_trj_rd;
    t_key_ent          r_key_rd;

    // Match and neighbor tracking
    logic              r_pat_hit;
    logic              r_trj_hit;
    logic              r_exact;
    logic [ANG_W-1:0]  r_exact_ang;
    logic              r_hb;
    logic [TIME_W-1:0] r_bt;
    logic [ANG_W-1:0]  r_ba;
    logic              r_ha;
    logic [TIME_W-1:0] r_at;
    logic [ANG_W-1:0]  r_aa;

    logic              r_valid;
    t_rsp              r_rsp;

    logic [IDX_W-1:0]  cur_cnt;
    logic              scan_more;
    logic              key_own;
    t_status           res_status;
    logic [ANG_W-1:0]  res_ang;
    logic [ANG_W:0]    ang_sum;
    logic              pat_full;
    logic              trj_full;
    logic              key_full;

    // Fill count of the table being scanned
    always_comb begin
        unique case (i_dp_cmd.phase)
            PH_PAT:  cur_cnt = IDX_W'(r_pat_cnt);
            PH_TRJ:  cur_cnt = IDX_W'(r_trj_cnt);
            PH_KEY:  cur_cnt = IDX_W'(r_key_cnt);
            default: cur_cnt = '0;
        endcase
    end

    assign scan_more = i_dp_cmd.scan && (r_idx < cur_cnt);

    // Scan index and read-valid pipeline bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_rd_vld <= 1'b0;
        end else if (i_dp_cmd.scan_init) begin
            r_idx    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= scan_more;
            if (scan_more) begin
                r_idx <= r_idx + IDX_W'(1);
            end
        end
    end

    // Registered memory reads
    always_ff @(posedge i_clk) begin
        if (scan_more) begin
            unique case (i_dp_cmd.phase)
                PH_PAT:  r_pat_rd <= pat_mem[r_idx[PAT_AW-1:0]];
                PH_TRJ:  r_trj_rd <= trj_mem[r_idx[TRJ_AW-1:0]];
                PH_KEY:  r_key_rd <= key_mem[r_idx[KEY_AW-1:0]];
                default: r_pat_rd <= r_pat_rd;
            endcase
        end
    end

    assign o_sts.scan_done = !scan_more && !r_rd_vld;
    assign o_sts.pat_hit   = r_pat_hit;
    assign o_sts.trj_hit   = r_trj_hit;
    assign o_sts.func      = r_cmd.func;

    assign key_own = (r_key_rd.pat_id == r_cmd.pat_id)
                  && (r_key_rd.srv_id == r_cmd.srv_id);

    // Command capture and compare of each entry read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd     <= '0;
            r_pat_hit <= 1'b0;
            r_trj_hit <= 1'b0;
            r_exact   <= 1'b0;
            r_hb      <= 1'b0;
            r_ha      <= 1'b0;
        end else if (i_dp_cmd.load) begin
            r_cmd     <= i_cmd;
            r_pat_hit <= 1'b0;
            r_trj_hit <= 1'b0;
            r_exact   <= 1'b0;
            r_hb      <= 1'b0;
            r_ha      <= 1'b0;
        end else if (r_rd_vld) begin
            unique case (i_dp_cmd.phase)
                PH_PAT: begin
                    if (r_pat_rd == r_cmd.pat_id) begin
                        r_pat_hit <= 1'b1;
                    end
                end
                PH_TRJ: begin
                    if (r_trj_rd.pat_id == r_cmd.pat_id
                            && r_trj_rd.srv_id == r_cmd.srv_id) begin
                        r_trj_hit <= 1'b1;
                    end
                end
                PH_KEY: begin
                    if (key_own) begin
                        priority if (r_key_rd.time_point == r_cmd.time_point) begin
                            r_exact     <= 1'b1;
                            r_exact_ang <= r_key_rd.angle;
                        end else if (r_key_rd.time_point < r_cmd.time_point) begin
                            if (!r_hb || r_key_rd.time_point > r_bt) begin
                                r_hb <= 1'b1;
                                r_bt <= r_key_rd.time_point;
                                r_ba <= r_key_rd.angle;
                            end
                        end else begin
                            if (!r_ha || r_key_rd.time_point < r_at) begin
                                r_ha <= 1'b1;
                                r_at <= r_key_rd.time_point;
                                r_aa <= r_key_rd.angle;
                            end
                        end
                    end
                end
                default: begin
                    r_pat_hit <= r_pat_hit;
                end
            endcase
        end
    end

    assign pat_full = (r_pat_cnt == PAT_CW'(MAX_PATTERNS));
    assign trj_full = (r_trj_cnt == TRJ_CW'(MAX_TRAJECTORIES));
    assign key_full = (r_key_cnt == KEY_CW'(MAX_KEYFRAMES));
    assign ang_sum  = {1'b0, r_ba} + {1'b0, r_aa};

    // Final status and angle
    always_comb begin
        res_status = ST_OK;
        res_ang    = '0;
        unique case (r_cmd.func)
            FN_ADD_PAT: begin
                priority if (r_pat_hit) res_status = ST_DUP;
                else if (pat_full)      res_status = ST_FULL;
                else                    res_status = ST_OK;
            end
            FN_ADD_TRAJ: begin
                priority if (!r_pat_hit) res_status = ST_NOPARENT;
                else if (r_trj_hit)      res_status = ST_DUP;
                else if (trj_full)       res_status = ST_FULL;
                else                     res_status = ST_OK;
            end
            FN_ADD_KEY: begin
                priority if (!r_pat_hit || !r_trj_hit) res_status = ST_NOPARENT;
                else if (r_exact)                      res_status = ST_DUP;
                else if (key_full)                     res_status = ST_FULL;
                else                                   res_status = ST_OK;
            end
            FN_GET_ANGLE: begin
                priority if (!r_pat_hit || !r_trj_hit) begin
                    res_status = ST_NOPARENT;
                end else if (r_exact) begin
                    res_status = ST_OK;
                    res_ang    = r_exact_ang;
                end else if (r_hb && r_ha) begin
                    res_status = ST_OK;
                    res_ang    = ang_sum[ANG_W:1];
                end else begin
                    res_status = ST_NONEIGHBOUR;
                end
            end
            default: begin
                res_status = ST_OK;
            end
        endcase
    end

    // Table writes on a successful add
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.finish && res_status == ST_OK) begin
            if (r_cmd.func == FN_ADD_PAT) begin
                pat_mem[r_pat_cnt[PAT_AW-1:0]] <= r_cmd.pat_id;
            end
            if (r_cmd.func == FN_ADD_TRAJ) begin
                trj_mem[r_trj_cnt[TRJ_AW-1:0]] <= {r_cmd.pat_id, r_cmd.srv_id};
            end
            if (r_cmd.func == FN_ADD_KEY) begin
                key_mem[r_key_cnt[KEY_AW-1:0]] <= {r_cmd.pat_id, r_cmd.srv_id,
                                                   r_cmd.time_point, r_cmd.angle};
            end
        end
    end

    // Fill counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_cnt <= '0;
            r_trj_cnt <= '0;
            r_key_cnt <= '0;
        end else if (i_dp_cmd.finish && res_status == ST_OK) begin
            if (r_cmd.func == FN_ADD_PAT) begin
                r_pat_cnt <= r_pat_cnt + PAT_CW'(1);
            end
            if (r_cmd.func == FN_ADD_TRAJ) begin
                r_trj_cnt <= r_trj_cnt + TRJ_CW'(1);
            end
            if (r_cmd.func == FN_ADD_KEY) begin
                r_key_cnt <= r_key_cnt + KEY_CW'(1);
            end
        end
    end

    // Result register and one-cycle strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_dp_cmd.finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.finish) begin
            r_rsp.status    <= res_status;
            r_rsp.angle_out <= res_ang;
        end
    end

    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

endmodule

### hdl/servo_keyframe_table.sv
// Top level of the servo keyframe table: controller plus datapath.
// Depends on svkf_pkg, svkf_ctrl and svkf_dp.
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+----------------
//  command   | start, busy (taken: start & !busy) | i_cmd (t_cmd)
//  result    | o_valid, one-cycle strobe  | o_rsp (t_rsp)
//
// One command at a time. The result waits on the pattern, trajectory and
// keyframe scans, one entry a cycle through the registered memory read, over
// the stored entries of each table. busy drops with the strobe, so the next
// command can be taken with the strobe. Scans stop early when the parent
// pattern or trajectory is missing.
// Reset is synchronous: all tables read as empty after it, no clearing pass.
// The result is shown for one cycle; the receiver cannot stall it.
module servo_keyframe_table (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  svkf_pkg::t_cmd i_cmd,
    output logic           o_valid,
    output svkf_pkg::t_rsp o_rsp
);
    import svkf_pkg::*;

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    // Sequencer
    svkf_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_sts    (dp_sts),
        .o_dp_cmd (dp_cmd)
    );

    // Tables and compare logic
    svkf_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (i_cmd),
        .i_dp_cmd (dp_cmd),
        .o_sts    (dp_sts),
        .o_valid  (o_valid),
        .o_rsp    (o_rsp)
    );

endmodule

### hdl/svkf_checker.sv
// Port-level checks for the servo keyframe table, bound to the top level.
// Depends on svkf_pkg.
module svkf_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           start,
    input logic           busy,
    input svkf_pkg::t_cmd i_cmd,
    input logic           o_valid,
    input svkf_pkg::t_rsp o_rsp
);
    import svkf_pkg::*;

    // A taken command keeps the block busy the next cycle
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after command transfer");

    // The fall of busy comes with the result strobe
    a_result_on_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_valid)
        else $error("busy dropped without a result");

    // Result strobe only while idle, and never two in a row
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!busy && !$past(o_valid)))
        else $error("result strobe out of place");

    // Failed operations carry a zero angle
    a_zero_angle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rsp.status != ST_OK) |-> (o_rsp.angle_out == '0))
        else $error("nonzero angle on a failed operation");

endmodule

bind servo_keyframe_table svkf_checker u_svkf_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .i_cmd   (i_cmd),
    .o_valid (o_valid),
    .o_rsp   (o_rsp)
);
